/* rtl/tkld_pkg.sv */
package tkld_pkg;

  localparam int unsigned LIST_DEPTH_DEF    = 16;
  localparam int unsigned TAG_BITS_DEF      = 16;
  localparam int unsigned DURATION_BITS_DEF = 48;

  localparam int unsigned KEEP_W = 7;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  localparam logic KIND_EVICT = 1'b0;
  localparam logic KIND_DUMP  = 1'b1;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins_en;  // insert the new entry, shifting smaller ones down
    logic rot_en;  // rotate the valid entries one place toward the head
  } ctl_t;

endpackage

/* rtl/tkld_cell.sv */
module tkld_cell
  import tkld_pkg::*;
#(
  parameter int unsigned TAG_BITS      = TAG_BITS_DEF,
  parameter int unsigned DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                     clk_i,
  input  ctl_t                     ctl_i,
  input  logic                     valid_i,
  input  logic                     tail_i,
  input  logic                     prev_ins_i,
  input  logic [TAG_BITS-1:0]      prev_tag_i,
  input  logic [DURATION_BITS-1:0] prev_dur_i,
  input  logic [TAG_BITS-1:0]      next_tag_i,
  input  logic [DURATION_BITS-1:0] next_dur_i,
  input  logic [TAG_BITS-1:0]      head_tag_i,
  input  logic [DURATION_BITS-1:0] head_dur_i,
  input  logic [TAG_BITS-1:0]      new_tag_i,
  input  logic [DURATION_BITS-1:0] new_dur_i,
  output logic                     ins_o,
  output logic [TAG_BITS-1:0]      tag_o,
  output logic [DURATION_BITS-1:0] dur_o,
  output logic [TAG_BITS-1:0]      tag_d_o,
  output logic [DURATION_BITS-1:0] dur_d_o
);

  logic [TAG_BITS-1:0]      tag_q, tag_d;
  logic [DURATION_BITS-1:0] dur_q, dur_d;

  // insertion point or below: new entry goes here or further up
  assign ins_o = !valid_i || (dur_q < new_dur_i);

  always_comb begin
    tag_d = tag_q;
    dur_d = dur_q;
    if (ctl_i.ins_en) begin
      if (prev_ins_i) begin
        tag_d = prev_tag_i;
        dur_d = prev_dur_i;
      end else if (ins_o) begin
        tag_d = new_tag_i;
        dur_d = new_dur_i;
      end
    end else if (ctl_i.rot_en && valid_i) begin
      if (tail_i) begin
        tag_d = head_tag_i;
        dur_d = head_dur_i;
      end else begin
        tag_d = next_tag_i;
        dur_d = next_dur_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    dur_q <= dur_d;
  end

  assign tag_o   = tag_q;
  assign dur_o   = dur_q;
  assign tag_d_o = tag_d;
  assign dur_d_o = dur_d;

endmodule

/* rtl/top_k_longest_durations.sv */
// Keeps the longest tagged durations in descending order in a row of cells,
// one entry per cell. On an insert (tuser 0) every cell compares its
// duration with the new one at once and the smaller entries shift one
// cell down; if the list then exceeds keep_limit (clipped to LIST_DEPTH)
// the smallest entry comes out as one eviction beat. Inserts can arrive
// every cycle as long as the output register is free. A dump (tuser 1)
// gives one beat per stored entry, each taken when the output register is
// free: the valid cells rotate toward cell 0, which drives each output beat,
// and after count beats the list is back in place. An empty dump gives one
// beat with item_valid low. New items are held off while a dump streams.
module top_k_longest_durations
  import tkld_pkg::*;
#(
  parameter int unsigned LIST_DEPTH    = LIST_DEPTH_DEF,
  parameter int unsigned TAG_BITS      = TAG_BITS_DEF,
  parameter int unsigned DURATION_BITS = DURATION_BITS_DEF,
  localparam int unsigned TDATA_W      = ((TAG_BITS + DURATION_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [KEEP_W-1:0]  cfg_data_i,      // keep_limit
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,  // new_tag, new_duration, zero pad
  input  logic               s_axis_tuser_i,  // operation
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,  // entry_tag, entry_duration, zero pad
  output logic [1:0]         m_axis_tuser_o,  // result_kind, item_valid
  output logic               m_axis_tlast_o   // last_item
);

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PAD_W = TDATA_W - TAG_BITS - DURATION_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic [KEEP_W-1:0] keep_limit_q;
  logic [KEEP_W-1:0] limit_eff;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              state_q, state_d;

  logic              out_valid_q, out_valid_d;
  logic              out_kind_q, out_kind_d;
  logic              out_item_q, out_item_d;
  logic              out_last_q, out_last_d;
  logic [TAG_BITS-1:0]      out_tag_q, out_tag_d;
  logic [DURATION_BITS-1:0] out_dur_q, out_dur_d;

  logic                     out_free, in_beat, evict;
  logic [TAG_BITS-1:0]      new_tag;
  logic [DURATION_BITS-1:0] new_dur;
  logic [TAG_BITS-1:0]      ev_tag;
  logic [DURATION_BITS-1:0] ev_dur;
  ctl_t                     ctl;

  logic                     c_valid [LIST_DEPTH];
  logic                     c_tail  [LIST_DEPTH];
  logic                     c_ins   [LIST_DEPTH];
  logic [TAG_BITS-1:0]      c_tag   [LIST_DEPTH];
  logic [DURATION_BITS-1:0] c_dur   [LIST_DEPTH];
  logic [TAG_BITS-1:0]      c_tag_d [LIST_DEPTH];
  logic [DURATION_BITS-1:0] c_dur_d [LIST_DEPTH];

  assign new_tag = s_axis_tdata_i[TAG_BITS-1:0];
  assign new_dur = s_axis_tdata_i[TAG_BITS +: DURATION_BITS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_limit_q <= KEEP_RESET;
    end else if (cfg_valid_i) begin
      keep_limit_q <= cfg_data_i;
    end
  end

  assign limit_eff = (keep_limit_q > KEEP_W'(LIST_DEPTH)) ? KEEP_W'(LIST_DEPTH)
                                                           : keep_limit_q;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  // count + 1 > limit
  assign evict           = KEEP_W'(count_q) >= limit_eff;

  always_comb begin
    ctl.ins_en = in_beat && (s_axis_tuser_i == OP_INSERT);
    ctl.rot_en = (state_q == ST_DUMP) && out_free;
  end

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic                     p_ins;
    logic [TAG_BITS-1:0]      p_tag, n_tag;
    logic [DURATION_BITS-1:0] p_dur, n_dur;

    assign c_valid[i] = CW'(i) < count_q;
    assign c_tail[i]  = CW'(i + 1) == count_q;

    if (i == 0) begin : g_first
      assign p_ins = 1'b0;
      assign p_tag = new_tag;
      assign p_dur = new_dur;
    end else begin : g_mid
      assign p_ins = c_ins[i-1];
      assign p_tag = c_tag[i-1];
      assign p_dur = c_dur[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_end
      assign n_tag = c_tag[0];
      assign n_dur = c_dur[0];
    end else begin : g_nxt
      assign n_tag = c_tag[i+1];
      assign n_dur = c_dur[i+1];
    end

    tkld_cell #(
      .TAG_BITS      (TAG_BITS),
      .DURATION_BITS (DURATION_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .valid_i    (c_valid[i]),
      .tail_i     (c_tail[i]),
      .prev_ins_i (p_ins),
      .prev_tag_i (p_tag),
      .prev_dur_i (p_dur),
      .next_tag_i (n_tag),
      .next_dur_i (n_dur),
      .head_tag_i (c_tag[0]),
      .head_dur_i (c_dur[0]),
      .new_tag_i  (new_tag),
      .new_dur_i  (new_dur),
      .ins_o      (c_ins[i]),
      .tag_o      (c_tag[i]),
      .dur_o      (c_dur[i]),
      .tag_d_o    (c_tag_d[i]),
      .dur_d_o    (c_dur_d[i])
    );
  end

  // Evicted entry is what lands in the first free slot; with a full list that
  // slot lies just past the last cell.
  always_comb begin
    ev_tag = '0;
    ev_dur = '0;
    for (int unsigned i = 0; i < LIST_DEPTH; i++) begin
      if (CW'(i) == count_q) begin
        ev_tag = ev_tag | c_tag_d[i];
        ev_dur = ev_dur | c_dur_d[i];
      end
    end
    if (CW'(LIST_DEPTH) == count_q) begin
      if (c_ins[LIST_DEPTH-1]) begin
        ev_tag = c_tag[LIST_DEPTH-1];
        ev_dur = c_dur[LIST_DEPTH-1];
      end else begin
        ev_tag = new_tag;
        ev_dur = new_dur;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_kind_d  = out_kind_q;
    out_item_d  = out_item_q;
    out_last_d  = out_last_q;
    out_tag_d   = out_tag_q;
    out_dur_d   = out_dur_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          if (s_axis_tuser_i == OP_INSERT) begin
            if (evict) begin
              out_valid_d = 1'b1;
              out_kind_d  = KIND_EVICT;
              out_item_d  = 1'b1;
              out_last_d  = 1'b1;
              out_tag_d   = ev_tag;
              out_dur_d   = ev_dur;
            end else begin
              count_d = count_q + 1'b1;
            end
          end else if (count_q == '0) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_DUMP;
            out_item_d  = 1'b0;
            out_last_d  = 1'b1;
            out_tag_d   = '0;
            out_dur_d   = '0;
          end else begin
            state_d = ST_DUMP;
            idx_d   = '0;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_DUMP;
          out_item_d  = 1'b1;
          out_last_d  = CW'(idx_q + 1'b1) == count_q;
          out_tag_d   = c_tag[0];
          out_dur_d   = c_dur[0];
          idx_d       = idx_q + 1'b1;
          if (CW'(idx_q + 1'b1) == count_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_item_q <= out_item_d;
    out_last_q <= out_last_d;
    out_tag_q  <= out_tag_d;
    out_dur_q  <= out_dur_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = {out_item_q, out_kind_q};
  assign m_axis_tlast_o  = out_last_q;

  if (PAD_W > 0) begin : g_pad
    assign m_axis_tdata_o = {{PAD_W{1'b0}}, out_dur_q, out_tag_q};
  end else begin : g_nopad
    assign m_axis_tdata_o = {out_dur_q, out_tag_q};
  end

endmodule
